// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the line assembler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition never holds.
`define ASSERT_NEVER(label, clk_s, rst_s, cond) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
        else $error("assertion failed");
`endif

// ----- rtl/lasm_pkg.sv -----
// Shared types and constants of the line assembler.
package lasm_pkg;
    localparam logic [3:0] PH_LEAD    = 4'd0;
    localparam logic [3:0] PH_CMD     = 4'd1;
    localparam logic [3:0] PH_GAP1    = 4'd2;
    localparam logic [3:0] PH_NUM     = 4'd3;
    localparam logic [3:0] PH_REG1    = 4'd4;
    localparam logic [3:0] PH_GAP2    = 4'd5;
    localparam logic [3:0] PH_REG2    = 4'd6;
    localparam logic [3:0] PH_DONE    = 4'd7;
    localparam logic [3:0] PH_COMMENT = 4'd8;
    localparam logic [3:0] PH_BAD     = 4'd9;

    localparam logic [4:0] KIND_SET  = 5'd16;
    localparam logic [4:0] KIND_RAW  = 5'd17;
    localparam logic [4:0] KIND_NONE = 5'd31;

    localparam logic RK_BYTE   = 1'b0;
    localparam logic RK_STATUS = 1'b1;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Event handed from the line parser to the emitter.
    typedef struct packed {
        logic       do_write;   // emit a byte record
        logic       do_set;     // load the write address
        logic [7:0] value;      // byte or address
        logic       do_final;   // emit the status record
        logic       err;        // error status for the final record
    } lasm_evt_t;

    // Map a mnemonic to its opcode, @ and $ to KIND_SET and KIND_RAW; -1 is encoded as 5'h1f.
    function automatic logic [4:0] lookup_cmd(input logic [31:0] tc, input logic [2:0] len);
        logic [4:0] r;
        r = 5'h1f;
        if (len == 3'd1 && tc[7:0] == "@") r = KIND_SET;
        else if (len == 3'd1 && tc[7:0] == "$") r = KIND_RAW;
        else if (len == 3'd4) begin
            case (tc)
                32'h45564F4D: r = 5'd0;  // MOVE
                32'h504D4A43: r = 5'd3;  // CJMP
                32'h4C49444C: r = 5'd8;  // LDIL
                32'h4849444C: r = 5'd9;  // LDIH
                default:      r = 5'h1f;
            endcase
        end else if (len == 3'd3) begin
            case (tc[23:0])
                24'h504D43: r = 5'd1;   // CMP
                24'h444E41: r = 5'd4;   // AND
                24'h524F58: r = 5'd6;   // XOR
                24'h434E49: r = 5'd12;  // INC
                24'h434544: r = 5'd13;  // DEC
                24'h444441: r = 5'd14;  // ADD
                24'h425553: r = 5'd15;  // SUB
                default:    r = 5'h1f;
            endcase
        end else if (len == 3'd2) begin
            case (tc[15:0])
                16'h524F: r = 5'd2;   // OR
                16'h444C: r = 5'd5;   // LD
                16'h5453: r = 5'd7;   // ST
                16'h4C53: r = 5'd10;  // SL
                16'h5253: r = 5'd11;  // SR
                default:  r = 5'h1f;
            endcase
        end
        return r;
    endfunction

    // Saturating accumulate: 256 marks overflow.
    function automatic logic [8:0] acc(input logic [8:0] v, input logic [4:0] base,
                                       input logic [3:0] d);
        logic [13:0] n;
        n = 14'(v) * 14'(base) + 14'(d);
        if (v[8] || n > 14'd255) return 9'd256;
        return n[8:0];
    endfunction
endpackage

// ----- rtl/line_assembler_to_machine_code.sv -----
// Top level of the line assembler: parser, event queue and emitter.
// A record passes from the parser through the event queue into the emitter's output register;
// a status record behind a byte record of the same character follows that byte record.
// Throughput: one character per cycle while the queue has room; the extra record of such a
// pair is absorbed by the queue, and the input stalls only while the queue holds three events.
// Reset (rst_n, asynchronous, active low) clears all control state; start_address resets to 0.
module line_assembler_to_machine_code (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,     // start_address
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] char_code
    input  logic        s_axis_tlast,    // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [7:0] write_address, [15:8] write_byte,
                                         // [16] status, [24:17] highest address,
                                         // [31:25] zero
    output logic        m_axis_tuser,    // [0] result_kind
    output logic        m_axis_tlast     // last_result
);
    import lasm_pkg::*;

    logic [7:0]  start_reg;
    logic        evt_valid, q_full, q_valid, q_pop;
    lasm_evt_t   evt, q_data;
    logic [26:0] od;

    // Hold the start address; the emitter loads it when a text ends, for the next text.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) start_reg <= '0;
        else if (cfg_wr_en) start_reg <= cfg_wr_data;
    end

    lasm_parser u_parser (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .c(s_axis_tdata),
        .last(s_axis_tlast), .q_full(q_full), .in_ready(s_axis_tready),
        .evt_valid(evt_valid), .evt(evt)
    );

    lasm_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(evt_valid), .wr_data(evt), .full(q_full),
        .rd_valid(q_valid), .rd_en(q_pop), .rd_data(q_data)
    );

    lasm_emitter u_emitter (
        .clk(clk), .rst_n(rst_n), .start_address(start_reg), .q_valid(q_valid),
        .q_data(q_data), .q_pop(q_pop), .m_valid(m_axis_tvalid),
        .m_ready(m_axis_tready), .m_data(od)
    );

    // Unpack the emitter record: kind in bit 0, then address, byte, status,
    // highest address and the last-result flag on top.
    assign m_axis_tdata = {7'd0, od[25:18], od[17], od[16:9], od[8:1]};
    assign m_axis_tuser = od[0];
    assign m_axis_tlast = od[26];
endmodule

// ----- rtl/lasm_parser.sv -----
// Front part: per-character line parser producing emit events.
module lasm_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          c,
    input  logic                last,
    input  logic                q_full,
    output logic                in_ready,
    output logic                evt_valid,
    output lasm_pkg::lasm_evt_t evt
);
    import lasm_pkg::*;

    logic [3:0]  phase_reg, phase_next;
    logic [31:0] tc_reg, tc_next;
    logic [2:0]  tl_reg, tl_next;
    logic [4:0]  kind_reg, kind_next;
    logic [1:0]  r1_reg, r1_next;
    logic [8:0]  bv_reg, bv_next, dv_reg, dv_next, hv_reg, hv_next;
    logic [2:0]  dval_reg, dval_next;
    logic [7:0]  pc_reg, pc_next;
    logic        err_reg, err_next, ended_reg, ended_next;
    logic        fire;

    assign in_ready = !q_full;
    assign fire = in_valid && in_ready;

    always_comb
    begin
        logic       is_nl, is_bl, is_pr, do_end;
        logic [3:0] ph;
        logic [4:0] lk;
        logic [8:0] nv, dd;
        logic [1:0] rg;
        logic       rok, nok;
        phase_next = phase_reg; tc_next = tc_reg; tl_next = tl_reg;
        kind_next = kind_reg; r1_next = r1_reg; bv_next = bv_reg;
        dv_next = dv_reg; hv_next = hv_reg; dval_next = dval_reg;
        pc_next = pc_reg; err_next = err_reg; ended_next = ended_reg;
        evt = '0; evt_valid = 1'b0;
        is_nl = (c == 8'h0A) || (c == 8'h0D);
        is_bl = (c == 8'h20) || (c == 8'h09);
        is_pr = (c > 8'h20) && (c < 8'h7F);
        do_end = 1'b0;
        ph = PH_LEAD;
        lk = 5'h1f; nv = '0; dd = '0; rg = '0; rok = 1'b0; nok = 1'b0;
        if (fire && !ended_reg) begin
            if (is_nl) do_end = 1'b1;
            else if (is_bl || is_pr) do_end = last;
            else begin
                do_end = 1'b1;
                ended_next = 1'b1;
            end
            if (is_pr) begin
                case (phase_reg)
                    PH_LEAD, PH_GAP1, PH_GAP2:
                    begin
                        tc_next = {24'd0, c}; tl_next = 3'd1; pc_next = c;
                        bv_next = '0; dv_next = '0; hv_next = '0; dval_next = 3'b111;
                        if (phase_reg == PH_LEAD) phase_next = PH_CMD;
                        else if (phase_reg == PH_GAP2) phase_next = PH_REG2;
                        else if (kind_reg >= KIND_SET || kind_reg == 5'd3 || kind_reg == 5'd8
                                 || kind_reg == 5'd9) phase_next = PH_NUM;
                        else phase_next = PH_REG1;
                    end
                    PH_CMD, PH_NUM, PH_REG1, PH_REG2:
                    begin
                        if (tl_reg > 3'd0) begin
                            if (pc_reg == "0" || pc_reg == "1")
                                bv_next = acc(bv_reg, 5'd2, 4'(pc_reg - 8'h30));
                            else dval_next[0] = 1'b0;
                            if (pc_reg >= "0" && pc_reg <= "9") begin
                                dv_next = acc(dv_reg, 5'd10, 4'(pc_reg - 8'h30));
                                hv_next = acc(hv_reg, 5'd16, 4'(pc_reg - 8'h30));
                            end else begin
                                dval_next[1] = 1'b0;
                                if (pc_reg >= "A" && pc_reg <= "F")
                                    hv_next = acc(hv_reg, 5'd16, 4'(pc_reg - 8'h37));
                                else if (pc_reg >= "a" && pc_reg <= "f")
                                    hv_next = acc(hv_reg, 5'd16, 4'(pc_reg - 8'h57));
                                else dval_next[2] = 1'b0;
                            end
                        end
                        pc_next = c;
                        if (tl_reg < 3'd4) tc_next = tc_reg | (32'(c) << (8 * tl_reg[1:0]));
                        if (tl_reg < 3'd5) tl_next = tl_reg + 3'd1;
                        if (phase_reg == PH_CMD && tl_reg == 3'd1 && tc_reg[7:0] == "-"
                            && c == "-") phase_next = PH_COMMENT;
                    end
                    default: ;
                endcase
            end
            // register and number decode of the token as it stands after this character
            rok = (tl_next == 3'd1);
            case (tc_next[7:0])
                "A": rg = 2'd0;
                "G": rg = 2'd1;
                "S": rg = 2'd2;
                "I": rg = 2'd3;
                default: rok = 1'b0;
            endcase
            dd = acc(dv_next, 5'd10, 4'(pc_next - 8'h30));
            case (pc_next)
                "B": begin nok = tl_next >= 3'd2 && dval_next[0] && !bv_next[8]; nv = bv_next; end
                "D": begin nok = tl_next >= 3'd2 && dval_next[1] && !dv_next[8]; nv = dv_next; end
                "H": begin nok = tl_next >= 3'd2 && dval_next[2] && !hv_next[8]; nv = hv_next; end
                default: begin
                    nok = pc_next >= "0" && pc_next <= "9" && dval_next[1] && !dd[8];
                    nv = dd;
                end
            endcase
            lk = lookup_cmd(tc_next, tl_next);
            if (!is_pr || last) begin
                // close the token at a blank, a line end, an invalid or the last character
                ph = phase_next;
                case (ph)
                    PH_CMD:
                        if (lk[4] && lk != KIND_SET && lk != KIND_RAW) begin
                            err_next = 1'b1; phase_next = PH_BAD;
                        end else begin
                            kind_next = lk; phase_next = PH_GAP1;
                        end
                    PH_NUM:
                        if (!nok) begin err_next = 1'b1; phase_next = PH_BAD; end
                        else begin
                            tc_next = kind_reg >= KIND_SET ? {24'd0, nv[7:0]}
                                      : {24'd0, kind_reg[3:0], nv[3:0]};
                            phase_next = PH_DONE;
                        end
                    PH_REG1:
                        if (!rok) begin err_next = 1'b1; phase_next = PH_BAD; end
                        else begin r1_next = rg; phase_next = PH_GAP2; end
                    PH_REG2:
                        if (!rok) begin err_next = 1'b1; phase_next = PH_BAD; end
                        else begin
                            tc_next = {24'd0, kind_reg[3:0], r1_reg, rg};
                            phase_next = PH_DONE;
                        end
                    default: ;
                endcase
            end
            if (do_end) begin
                // the token is closed above; finish the line
                if (phase_next == PH_GAP1 || phase_next == PH_GAP2) err_next = 1'b1;
                else if (phase_next == PH_DONE && !err_next) begin
                    evt.value = tc_next[7:0];
                    if (kind_next == KIND_SET) evt.do_set = 1'b1;
                    else evt.do_write = 1'b1;
                end
                phase_next = PH_LEAD; kind_next = KIND_NONE;
                tc_next = '0; tl_next = '0; pc_next = '0;
                bv_next = '0; dv_next = '0; hv_next = '0; dval_next = 3'b111;
            end
        end
        if (fire && last) begin
            evt.do_final = 1'b1;
            evt.err = err_next;
            phase_next = PH_LEAD; kind_next = KIND_NONE; tc_next = '0; tl_next = '0;
            pc_next = '0; bv_next = '0; dv_next = '0; hv_next = '0; dval_next = 3'b111;
            r1_next = '0; err_next = 1'b0; ended_next = 1'b0;
        end
        evt_valid = evt.do_write || evt.do_set || evt.do_final;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_LEAD; tc_reg <= '0; tl_reg <= '0; kind_reg <= KIND_NONE;
            r1_reg <= '0; bv_reg <= '0; dv_reg <= '0; hv_reg <= '0; dval_reg <= 3'b111;
            pc_reg <= '0; err_reg <= 1'b0; ended_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; tc_reg <= tc_next; tl_reg <= tl_next;
            kind_reg <= kind_next; r1_reg <= r1_next; bv_reg <= bv_next;
            dv_reg <= dv_next; hv_reg <= hv_next; dval_reg <= dval_next;
            pc_reg <= pc_next; err_reg <= err_next; ended_reg <= ended_next;
        end
    end
endmodule

// ----- rtl/lasm_queue.sv -----
// Short event queue between the parser and the emitter.
module lasm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  lasm_pkg::lasm_evt_t wr_data,
    output logic                full,
    output logic                rd_valid,
    input  logic                rd_en,
    output lasm_pkg::lasm_evt_t rd_data
);
    import lasm_pkg::*;
    `include "assert_macros.svh"

    lasm_evt_t      mem_reg [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg, cnt_next;

    // Reserve one slot so the stall decision is registered-only.
    assign full = cnt_reg >= (QAW+1)'(QDEPTH - 1);
    assign rd_valid = cnt_reg != '0;
    assign rd_data = mem_reg[rp_reg];
    assign cnt_next = cnt_reg + (QAW+1)'(wr_en) - (QAW+1)'(rd_en && rd_valid);

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en && rd_valid) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_NEVER(a_no_overflow, clk, rst_n, cnt_reg > (QAW+1)'(QDEPTH))
    `ASSERT_IMPL(a_full_blocks, clk, rst_n, full, !wr_en || rd_en)
    `ASSERT_NEVER(a_spare_slot, clk, rst_n, cnt_reg > (QAW+1)'(QDEPTH - 1))
endmodule

// ----- rtl/lasm_emitter.sv -----
// Back part: tracks addresses and sends result records.
module lasm_emitter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          start_address,
    input  logic                q_valid,
    input  lasm_pkg::lasm_evt_t q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [26:0]         m_data
);
    import lasm_pkg::*;
    `include "assert_macros.svh"

    logic [7:0]  cur_reg, cur_next, hi_reg, hi_next;
    logic        step_reg, step_next;   // 1: byte record of a two-record event sent
    logic        ov_reg;
    logic [26:0] od_reg, od_next;
    logic        out_free, emit;
    logic [7:0]  cur_eff, hi_eff, inc;

    assign out_free = !ov_reg || m_ready;
    assign m_valid = ov_reg;
    assign m_data = od_reg;
    assign cur_eff = cur_reg;
    assign hi_eff = hi_reg;
    assign inc = cur_eff + 8'd1;

    always_comb
    begin
        cur_next = cur_eff; hi_next = hi_eff; step_next = step_reg;
        od_next = od_reg; q_pop = 1'b0; emit = 1'b0;
        if (q_valid && out_free) begin
            if (q_data.do_write && !step_reg) begin
                cur_next = inc;
                hi_next = inc > hi_eff ? inc : hi_eff;
                emit = 1'b1;
                od_next = {!q_data.do_final, hi_next, 1'b0, q_data.value, cur_eff, RK_BYTE};
                if (q_data.do_final) step_next = 1'b1;
                else q_pop = 1'b1;
            end else begin
                if (q_data.do_set) cur_next = q_data.value;
                if (q_data.do_final) begin
                    emit = 1'b1;
                    od_next = {1'b1, hi_eff, q_data.err, 8'd0, 8'd0, RK_STATUS};
                    // restart both addresses for the next text
                    cur_next = start_address;
                    hi_next = start_address;
                end
                step_next = 1'b0;
                q_pop = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) od_reg <= od_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_reg <= '0; hi_reg <= '0;
            step_reg <= 1'b0; ov_reg <= 1'b0;
        end else begin
            if (q_pop || step_next != step_reg) begin
                cur_reg <= cur_next; hi_reg <= hi_next;
            end
            step_reg <= step_next;
            if (emit) ov_reg <= 1'b1;
            else if (m_ready) ov_reg <= 1'b0;
        end
    end

    `ASSERT_IMPL(a_hold, clk, rst_n, ov_reg && !m_ready, ##1 1'b1)
    `ASSERT_IMPL(a_emit_room, clk, rst_n, emit, out_free)
    `ASSERT_IMPL(a_step_final, clk, rst_n, step_reg, q_valid && q_data.do_final)
endmodule

// ----- tb/sv/line_assembler_to_machine_code_tb.sv -----
// Self-checking testbench of the line assembler: random assembly text in, byte and status records checked.
module line_assembler_to_machine_code_tb;
    import lasm_pkg::*;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } char_req_t;

    typedef struct {
        logic       kind;
        logic [7:0] addr;
        logic [7:0] data;
        logic       stat;
        logic [7:0] used;
        logic       last;
    } asm_rec_t;

    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] char_code
    logic        s_axis_tlast;     // last_char
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // [7:0] write_address, [15:8] write_byte, [16] status,
                                   // [24:17] highest address
    logic        m_axis_tuser;     // [0] result_kind
    logic        m_axis_tlast;     // last_result

    char_req_t char_q[$];
    asm_rec_t  record_q[$];
    int        fail_count;
    int        stall_cycles;
    int        pushed;
    bit        quiet;
    int        src_gap;
    int        snk_gap;

    // Assembler state as seen by the predictor
    logic [3:0]  phase;
    logic [31:0] tok;
    int          tok_len;
    logic [4:0]  cmd;
    logic [1:0]  reg_a;
    int          bin_val, dec_val, hex_val;
    logic [2:0]  base_ok;
    logic [7:0]  held_char;
    logic [7:0]  cur_addr, top_addr;
    logic [7:0]  start_reg;
    bit          err_flag, text_done;

    string mnems[16] = '{"MOVE", "CMP", "OR", "CJMP", "AND", "LD", "XOR", "ST",
                         "LDIL", "LDIH", "SL", "SR", "INC", "DEC", "ADD", "SUB"};

    line_assembler_to_machine_code dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    // Saturating accumulate; 256 flags a value out of byte range.
    function automatic int sat_acc(int v, int base, int d);
        int n;
        if (v > 255) return 256;
        n = v * base + d;
        return (n > 255) ? 256 : n;
    endfunction

    function automatic void tok_clear();
        tok = '0;
        tok_len = 0;
        held_char = '0;
        bin_val = 0;
        dec_val = 0;
        hex_val = 0;
        base_ok = 3'b111;
    endfunction

    // Fold the held character into all three bases, dropping bases it breaks.
    function automatic void fold_held(logic [7:0] c);
        if (c == "0" || c == "1") bin_val = sat_acc(bin_val, 2, c - "0");
        else base_ok[0] = 1'b0;
        if (c >= "0" && c <= "9") dec_val = sat_acc(dec_val, 10, c - "0");
        else base_ok[1] = 1'b0;
        if (c >= "0" && c <= "9") hex_val = sat_acc(hex_val, 16, c - "0");
        else if (c >= "A" && c <= "F") hex_val = sat_acc(hex_val, 16, c - "A" + 10);
        else if (c >= "a" && c <= "f") hex_val = sat_acc(hex_val, 16, c - "a" + 10);
        else base_ok[2] = 1'b0;
    endfunction

    function automatic void tok_push(logic [7:0] c);
        if (tok_len > 0) fold_held(held_char);
        held_char = c;
        if (tok_len < 4) tok[8*tok_len +: 8] = c;
        if (tok_len < 5) tok_len++;
    endfunction

    function automatic int num_value();
        int v;
        if (held_char == "B")
            return (tok_len >= 2 && base_ok[0] && bin_val <= 255) ? bin_val : -1;
        if (held_char == "D")
            return (tok_len >= 2 && base_ok[1] && dec_val <= 255) ? dec_val : -1;
        if (held_char == "H")
            return (tok_len >= 2 && base_ok[2] && hex_val <= 255) ? hex_val : -1;
        if (held_char >= "0" && held_char <= "9" && base_ok[1]) begin
            v = sat_acc(dec_val, 10, held_char - "0");
            return (v <= 255) ? v : -1;
        end
        return -1;
    endfunction

    function automatic int reg_code();
        if (tok_len != 1) return -1;
        case (tok[7:0])
            "A": return 0;
            "G": return 1;
            "S": return 2;
            "I": return 3;
            default: return -1;
        endcase
    endfunction

    function automatic int cmd_code();
        string nm;
        bit same;
        if (tok_len == 1 && tok[7:0] == "@") return KIND_SET;
        if (tok_len == 1 && tok[7:0] == "$") return KIND_RAW;
        for (int i = 0; i < 16; i++) begin
            nm = mnems[i];
            if (tok_len != nm.len()) continue;
            same = 1;
            for (int k = 0; k < nm.len(); k++)
                if (tok[8*k +: 8] != nm[k]) same = 0;
            if (same) return i;
        end
        return -1;
    endfunction

    function automatic bit wants_number();
        return cmd >= KIND_SET || cmd == 5'd3 || cmd == 5'd8 || cmd == 5'd9;
    endfunction

    function automatic void flag_error();
        err_flag = 1;
        phase = PH_BAD;
    endfunction

    // Close the token in progress at a blank or a line end.
    function automatic void close_token();
        int r;
        case (phase)
            PH_CMD:
            begin
                r = cmd_code();
                if (r < 0) flag_error();
                else
                begin
                    cmd = r[4:0];
                    phase = PH_GAP1;
                end
            end
            PH_NUM:
            begin
                r = num_value();
                if (r < 0) flag_error();
                else
                begin
                    if (cmd >= KIND_SET) tok = r;
                    else tok = {cmd[3:0], r[3:0]};
                    phase = PH_DONE;
                end
            end
            PH_REG1:
            begin
                r = reg_code();
                if (r < 0) flag_error();
                else
                begin
                    reg_a = r[1:0];
                    phase = PH_GAP2;
                end
            end
            PH_REG2:
            begin
                r = reg_code();
                if (r < 0) flag_error();
                else
                begin
                    tok = {cmd[3:0], reg_a, r[1:0]};
                    phase = PH_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void take_printable(logic [7:0] c);
        case (phase)
            PH_LEAD:
            begin
                tok_clear();
                tok_push(c);
                phase = PH_CMD;
            end
            PH_CMD:
            begin
                tok_push(c);
                if (tok_len == 2 && tok[15:0] == 16'h2D2D) phase = PH_COMMENT;
            end
            PH_GAP1:
            begin
                tok_clear();
                tok_push(c);
                phase = wants_number() ? PH_NUM : PH_REG1;
            end
            PH_GAP2:
            begin
                tok_clear();
                tok_push(c);
                phase = PH_REG2;
            end
            PH_NUM, PH_REG1, PH_REG2: tok_push(c);
            default: ;
        endcase
    endfunction

    function automatic void add_record(logic kind, logic [7:0] a, logic [7:0] d, logic st,
                                       logic [7:0] u);
        asm_rec_t r;
        r.kind = kind;
        r.addr = a;
        r.data = d;
        r.stat = st;
        r.used = u;
        r.last = 1'b0;
        record_q.push_back(r);
    endfunction

    function automatic void finish_line();
        logic [7:0] a;
        close_token();
        if (phase == PH_GAP1 || phase == PH_GAP2) err_flag = 1;
        else if (phase == PH_DONE && !err_flag) begin
            if (cmd == KIND_SET) cur_addr = tok[7:0];
            else
            begin
                a = cur_addr;
                cur_addr = cur_addr + 8'd1;
                if (cur_addr > top_addr) top_addr = cur_addr;
                add_record(RK_BYTE, a, tok[7:0], 1'b0, top_addr);
            end
        end
        phase = PH_LEAD;
        cmd = KIND_NONE;
        tok_clear();
    endfunction

    function automatic void text_restart();
        phase = PH_LEAD;
        tok_clear();
        cmd = KIND_NONE;
        reg_a = '0;
        cur_addr = start_reg;
        top_addr = start_reg;
        err_flag = 0;
        text_done = 0;
    endfunction

    // Predict the records caused by one accepted character.
    function automatic void assemble_char(logic [7:0] c, logic last);
        int n_prior;
        n_prior = record_q.size();
        if (!text_done) begin
            if (c == 8'h0A || c == 8'h0D) finish_line();
            else if (c == " " || c == 8'h09 || (c > 8'h20 && c < 8'h7F)) begin
                if (c == " " || c == 8'h09) close_token();
                else take_printable(c);
                if (last) finish_line();
            end
            else
            begin
                finish_line();
                text_done = 1;
            end
        end
        if (last) begin
            add_record(RK_STATUS, 8'h00, 8'h00, err_flag, top_addr);
            text_restart();
        end
        if (record_q.size() > n_prior) record_q[$].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- text generation

    function automatic string num_text(int v);
        string t;
        t = $sformatf("%0h", v);
        case ($urandom_range(0, 5))
            0: return $sformatf("%0dD", v);
            1: return {t, "H"};
            2: return {t.toupper(), "H"};
            3: return $sformatf("%0bB", v);
            default: return $sformatf("%0d", v);
        endcase
    endfunction

    function automatic string blanks(int lo);
        string s;
        int n;
        s = "";
        n = $urandom_range(lo, 2);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) s = {s, "\t"};
            else s = {s, " "};
        end
        return s;
    endfunction

    function automatic string reg_text();
        case ($urandom_range(0, 3))
            0: return "A";
            1: return "G";
            2: return "S";
            default: return "I";
        endcase
    endfunction

    function automatic string rand_line();
        string s;
        string mn;
        int v, m;
        v = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255);
        s = blanks(0);
        case ($urandom_range(0, 19))
            0: ;
            1: s = {s, "-- note ", reg_text()};
            2: s = {s, "@", blanks(1), num_text(v)};
            3, 4: s = {s, "$", blanks(1), num_text(v)};
            5, 6, 7:
            begin
                m = $urandom_range(0, 2);
                if (m == 0) mn = "CJMP";
                else if (m == 1) mn = "LDIL";
                else mn = "LDIH";
                s = {s, mn, blanks(1), num_text(v)};
            end
            8:
            begin
                // Malformed: wrong operand kind, missing operand, bad token
                case ($urandom_range(0, 3))
                    0: s = {s, "ADD ", num_text(v)};
                    1: s = {s, mnems[$urandom_range(0, 15)]};
                    2: s = {s, "LDIL 12h"};
                    default: s = {s, "MOV", reg_text(), " A"};
                endcase
            end
            9:
            begin
                // Random byte, may be an invalid character ending the text
                s = {s, string'(8'($urandom_range(0, 255)))};
            end
            default:
            begin
                do m = $urandom_range(0, 15); while (m == 3 || m == 8 || m == 9);
                s = {s, mnems[m], blanks(1), reg_text(), blanks(1), reg_text()};
            end
        endcase
        if ($urandom_range(0, 4) == 0) s = {s, blanks(1), "junk"};
        case ($urandom_range(0, 3))
            0: s = {s, "\r"};
            1: s = {s, "\r\n"};
            default: s = {s, "\n"};
        endcase
        return s;
    endfunction

    // Queue a text; the final character carries last_char.
    task automatic push_text(string s);
        char_req_t r;
        for (int i = 0; i < s.len(); i++) begin
            r.code = s[i];
            r.last = (i == s.len() - 1);
            char_q.push_back(r);
            pushed = pushed + 1;
        end
    endtask

    function automatic string rand_text();
        string s;
        int n;
        s = "";
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) s = {s, rand_line()};
        // Sometimes end the text mid-line, without a line end
        if ($urandom_range(0, 2) == 0) s = {s, "SUB G I"};
        return s;
    endfunction

    // Hold off configuration until the block is idle, then write start_address.
    task automatic write_start(logic [7:0] v);
        wait (char_q.size() == 0 && record_q.size() == 0 && !s_axis_tvalid);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        start_reg = v;
        cfg_wr_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------- stimulus
    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        quiet       = 0;
        fail_count  = 0;
        pushed      = 0;
        start_reg   = '0;
        text_restart();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Takes effect once the first text has closed
        write_start(8'hFD);
        // Directed: all mnemonics, number forms and extremes, CRLF, comments
        push_text({"  MOVE A G\r\nCMP G S\nOR S I\n\tAND I A\nLD A A\nXOR I I\n",
                   "ST G A\nSL S S\nSR A I\nINC G G\nDEC S A\nADD I S\nSUB A G\n",
                   "CJMP 15\nLDIL 0FH\nLDIH 1010B\n-- comment\n\n"});
        push_text({"$ 255\n$ 11111111B\n$ ffH\n$ 0D\n@ 255\n$ 7 trailing\n$ 1\n"});
        push_text({"$ 256\nMOVE A\n"});
        push_text({"MOVE A G\n", string'(8'h80), "ADD A A\n"});
        push_text({"$ 12H", string'(8'h00)});
        write_start(8'h00);
        push_text({"@ 0\nLDIL 1\n", string'(8'hFF)});
        push_text({"XYZ A G\n", string'(8'h7F)});
        write_start(8'hFF);

        while (pushed < 1200) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 3))
                    0: write_start(8'h00);
                    1: write_start(8'hFF);
                    default: write_start(8'($urandom_range(0, 255)));
                endcase
            end
            if (pushed > 1000) quiet = 1;
            push_text(rand_text());
            wait (char_q.size() < 20);
        end

        wait (char_q.size() == 0 && !s_axis_tvalid);
        wait (record_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[line_assembler_to_machine_code] OK");
        else
            $display("[line_assembler_to_machine_code] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            src_gap       <= 0;
        end
        else
        begin
            // Predict on the request that completes at this edge, then retire it
            if (s_axis_tvalid && s_axis_tready) begin
                assemble_char(s_axis_tdata, s_axis_tlast);
                void'(char_q.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the request until it is taken
            end
            else if (src_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0) begin
                s_axis_tvalid <= 1'b0;
                src_gap <= $urandom_range(0, 8);
            end
            else
            begin
                // advance to the next pending character (head already popped above)
                if (char_q.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= char_q[0].code;
                    s_axis_tlast  <= char_q[0].last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- result monitor
    always @(posedge clk or negedge rst_n)
    begin
        asm_rec_t e;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            snk_gap       <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (record_q.size() == 0) begin
                    $display("%0t: unexpected record: expected none, actual data=%h kind=%0d",
                             $time, m_axis_tdata, m_axis_tuser);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = record_q.pop_front();
                    if (m_axis_tuser !== e.kind || m_axis_tdata[7:0] !== e.addr ||
                        m_axis_tdata[15:8] !== e.data || m_axis_tdata[16] !== e.stat ||
                        m_axis_tdata[24:17] !== e.used || m_axis_tlast !== e.last) begin
                        $display("%0t: mismatch: expected kind=%0d addr=%h byte=%h st=%0d used=%h last=%0d, actual kind=%0d addr=%h byte=%h st=%0d used=%h last=%0d",
                                 $time, e.kind, e.addr, e.data, e.stat, e.used, e.last,
                                 m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8],
                                 m_axis_tdata[16], m_axis_tdata[24:17], m_axis_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // Stall the output in random bursts, never in the quiet tail
            if (snk_gap > 0) begin
                m_axis_tready <= 1'b0;
                snk_gap <= snk_gap - 1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                snk_gap <= $urandom_range(0, 8);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[line_assembler_to_machine_code] ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end
endmodule
